// ----- rtl/twst_pkg.sv -----
// ----------------------------------------------------------------------------
// twst_pkg
// Shared widths, operation codes and result status codes of the timer wheel
// sleep table.
// ----------------------------------------------------------------------------
package twst_pkg;

    localparam int MODE_W       = 3;
    localparam int SLOT_FW      = 6;
    localparam int TICK_W       = 32;
    localparam int STAT_W       = 2;
    localparam int CFG_W        = 7;

    // wheel bucket count is a power of two, bucket = low bits of the tick
    localparam int WHEEL_BITS    = 9;
    localparam int WHEEL_BUCKETS = 1 << WHEEL_BITS;

    localparam int TASK_SLOTS_DEF = 64;
    localparam int MAX_READY_RST  = 64;

    localparam logic [MODE_W-1:0] MODE_SLEEP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAKE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COLLECT = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTWAIT = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

    localparam logic [1:0] SM_RUNNING = 2'd0;
    localparam logic [1:0] SM_INTR    = 2'd1;
    localparam logic [1:0] SM_UNINTR  = 2'd2;

endpackage

// ----- rtl/timer_wheel_sleep_table_core.sv -----
// ----------------------------------------------------------------------------
// timer_wheel_sleep_table_core
// Sleep table of task slots on a hashed timing wheel with a 32-bit tick count.
// ----------------------------------------------------------------------------
// One command beat is taken at a time; the input is not ready until the
// command has finished. Sleep, wait, wake and tick pass through accept and
// execute, and the first three wait in execute for the result register.
// Collect walks every task slot in ascending order through one wake-time
// memory read port and one comparator, reading then comparing each slot,
// stopping early once max_ready slots are released and holding while a
// released slot waits for the output. Each released slot becomes one result
// beat; the last beat of a command carries tlast. A collect that releases
// nothing returns slot 0 with status "none ready". The configuration
// port is always ready and must only be written while the block is idle.
module timer_wheel_sleep_table_core #(
    parameter int TASK_SLOTS = twst_pkg::TASK_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [5:0] task_slot, [37:6] sleep_ticks, [39:38] zero
    input  logic [39:0]                      i_s_axis_tdata,
    // [2:0] mode
    input  logic [twst_pkg::MODE_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [5:0] out_slot, [7:6] zero
    output logic [7:0]                       o_m_axis_tdata,
    // [1:0] status
    output logic [twst_pkg::STAT_W-1:0]      o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    // max_ready register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [twst_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int SFW    = twst_pkg::SLOT_FW;
    localparam int TW     = twst_pkg::TICK_W;
    localparam int WB     = twst_pkg::WHEEL_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [twst_pkg::MODE_W-1:0]  r_mode;
    logic [SFW-1:0]               r_slot;
    logic [TW-1:0]                r_ticks;
    logic [TW-1:0]                r_now;
    logic [twst_pkg::CFG_W-1:0]   r_max_ready;

    logic [TASK_SLOTS-1:0]        r_on_wheel;
    logic [1:0]                   r_slot_mode [TASK_SLOTS];
    logic [TW-1:0]                r_wake_mem  [TASK_SLOTS];

    logic [CNT_W-1:0]             r_scan;
    logic [twst_pkg::CFG_W-1:0]   r_count;
    logic [TW-1:0]                r_rd_data;
    logic                         r_rd_wheel;
    logic                         r_pend_v;
    logic [SLOT_W-1:0]            r_pend;

    logic                         r_ov;
    logic [SFW-1:0]               r_oslot;
    logic [twst_pkg::STAT_W-1:0]  r_ostat;
    logic                         r_olast;

    logic [TW-1:0]                w_sum;
    logic                         w_slot_ok;
    logic [SLOT_W-1:0]            w_idx;
    logic [SLOT_W-1:0]            w_scan_idx;
    logic                         w_can_load;
    logic                         w_hit;
    logic                         w_mem_we;
    logic                         w_rd_en;
    logic [TASK_SLOTS-1:0]        w_mode_intr;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(8-SFW){1'b0}}, r_oslot};
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;

    // shared adder: tick increments, timed sleep adds the tick count
    assign w_sum      = r_now + ((r_mode == twst_pkg::MODE_TICK) ? TW'(1) : r_ticks);
    assign w_slot_ok  = ({1'b0, r_slot} < (SFW+1)'(TASK_SLOTS));
    assign w_idx      = r_slot[SLOT_W-1:0];
    assign w_scan_idx = r_scan[SLOT_W-1:0];
    assign w_can_load = !r_ov || i_m_axis_tready;

    // single comparator path: bucket match and wakeup not later than now
    assign w_hit = r_rd_wheel
                && (r_rd_data[WB-1:0] == r_now[WB-1:0])
                && (r_rd_data <= r_now);

    assign w_mem_we = (r_state == S_EXEC) && (r_mode == twst_pkg::MODE_SLEEP)
                   && w_slot_ok && (r_ticks != '0);
    assign w_rd_en  = (r_state == S_RD) && (r_scan != CNT_W'(TASK_SLOTS))
                   && (r_count < r_max_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_mode)
                    twst_pkg::MODE_SLEEP, twst_pkg::MODE_WAIT, twst_pkg::MODE_WAKE: begin
                        if (w_can_load) n_state = S_IDLE;
                    end
                    twst_pkg::MODE_COLLECT: n_state = S_RD;
                    default:                n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                n_state = w_rd_en ? S_CMP : S_FIN;
            end
            S_CMP: begin
                if (!(w_hit && r_pend_v && !w_can_load)) n_state = S_RD;
            end
            S_FIN: begin
                if (w_can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_max_ready <= twst_pkg::CFG_W'(twst_pkg::MAX_READY_RST);
            r_on_wheel  <= '0;
            r_pend_v    <= 1'b0;
            r_ov        <= 1'b0;
            r_scan      <= '0;
            r_count     <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) r_slot_mode[i] <= twst_pkg::SM_RUNNING;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_max_ready <= i_cfg_data;
            if (r_ov && i_m_axis_tready) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_mode  <= i_s_axis_tuser;
                        r_slot  <= i_s_axis_tdata[SFW-1:0];
                        r_ticks <= i_s_axis_tdata[SFW +: TW];
                    end
                end
                S_EXEC: begin
                    unique case (r_mode)
                        twst_pkg::MODE_SLEEP, twst_pkg::MODE_WAIT: begin
                            if (w_can_load) begin
                                if (w_slot_ok) begin
                                    if (r_mode == twst_pkg::MODE_SLEEP && r_ticks != '0) begin
                                        r_on_wheel[w_idx]  <= 1'b1;
                                        r_slot_mode[w_idx] <= twst_pkg::SM_INTR;
                                    end else begin
                                        r_on_wheel[w_idx]  <= 1'b0;
                                        r_slot_mode[w_idx] <= (r_mode == twst_pkg::MODE_WAIT)
                                                            ? twst_pkg::SM_UNINTR
                                                            : twst_pkg::SM_INTR;
                                    end
                                end
                                r_ov    <= 1'b1;
                                r_oslot <= r_slot;
                                r_ostat <= twst_pkg::ST_OK;
                                r_olast <= 1'b1;
                            end
                        end
                        twst_pkg::MODE_WAKE: begin
                            if (w_can_load) begin
                                r_ov    <= 1'b1;
                                r_oslot <= r_slot;
                                r_olast <= 1'b1;
                                if (w_slot_ok && r_slot_mode[w_idx] != twst_pkg::SM_RUNNING) begin
                                    r_on_wheel[w_idx]  <= 1'b0;
                                    r_slot_mode[w_idx] <= twst_pkg::SM_RUNNING;
                                    r_ostat <= twst_pkg::ST_OK;
                                end else begin
                                    r_ostat <= twst_pkg::ST_NOTWAIT;
                                end
                            end
                        end
                        twst_pkg::MODE_TICK: r_now <= w_sum;
                        twst_pkg::MODE_COLLECT: begin
                            r_scan   <= '0;
                            r_count  <= '0;
                            r_pend_v <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_RD: ;
                S_CMP: begin
                    if (!(w_hit && r_pend_v && !w_can_load)) begin
                        r_scan <= r_scan + CNT_W'(1);
                        if (w_hit) begin
                            // previous match is not the final one: send it now
                            if (r_pend_v) begin
                                r_ov    <= 1'b1;
                                r_oslot <= SFW'(r_pend);
                                r_ostat <= twst_pkg::ST_TIMEOUT;
                                r_olast <= 1'b0;
                            end
                            r_pend_v                <= 1'b1;
                            r_pend                  <= w_scan_idx;
                            r_count                 <= r_count + twst_pkg::CFG_W'(1);
                            r_on_wheel[w_scan_idx]  <= 1'b0;
                            r_slot_mode[w_scan_idx] <= twst_pkg::SM_RUNNING;
                        end
                    end
                end
                S_FIN: begin
                    if (w_can_load) begin
                        r_ov     <= 1'b1;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        if (r_pend_v) begin
                            r_oslot <= SFW'(r_pend);
                            r_ostat <= twst_pkg::ST_TIMEOUT;
                        end else begin
                            r_oslot <= '0;
                            r_ostat <= twst_pkg::ST_NONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // wake-time memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_wake_mem[w_idx] <= w_sum;
        if (w_rd_en) begin
            r_rd_data  <= r_wake_mem[w_scan_idx];
            r_rd_wheel <= r_on_wheel[w_scan_idx];
        end
    end

    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            w_mode_intr[i] = (r_slot_mode[i] == twst_pkg::SM_INTR);
        end
    end

`ifndef SYNTH
    a_pend_in_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_RD || r_state == S_CMP || r_state == S_FIN))
        else $error("pending release outside collect");

    a_wheel_is_intr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on_wheel & ~w_mode_intr) == '0)
        else $error("slot on wheel without interruptible mode");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= twst_pkg::CFG_W'(TASK_SLOTS))
        else $error("release count beyond slot count");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_mode == twst_pkg::MODE_TICK)
        |=> r_now == $past(r_now) + TW'(1))
        else $error("tick did not advance time by one");
`endif

endmodule

// ----- sim/timer_wheel_sleep_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// timer_wheel_sleep_table_core_tb
// Self-checking bench for the timer wheel sleep table. Commands go in on the
// slave stream. A scoreboard keeps its own copy of the slot table and the tick
// count, works out the beats each command should return, and compares them in
// order with the master stream. The run walks through several max_ready
// settings and through source and sink idle patterns.
// ----------------------------------------------------------------------------
module timer_wheel_sleep_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = twst_pkg::TASK_SLOTS_DEF;
    localparam int QUIET_MAX  = 3000;
    localparam int SEG_ITEMS  = 32;
    localparam int DIRECTED   = 24;

    localparam logic [twst_pkg::MODE_W-1:0] MODE_ERR_BASE = 3'd5;   // first unused mode

    typedef struct packed {
        logic [twst_pkg::SLOT_FW-1:0] slot;
        logic [twst_pkg::STAT_W-1:0]  status;
        logic                         last;
    } t_result_beat;

    class t_sleep_table_sb;
        logic [twst_pkg::TICK_W-1:0] now_count;
        bit                          filed_wheel [NSLOT];
        bit                          filed_wait [NSLOT];
        logic [twst_pkg::TICK_W-1:0] due_tick [NSLOT];
        logic [1:0]                  slot_state [NSLOT];
        logic [twst_pkg::CFG_W-1:0]  ready_cap;
        t_result_beat                due_beats [$];
        int                          errors;

        function new();
            now_count = '0;
            ready_cap = twst_pkg::CFG_W'(twst_pkg::MAX_READY_RST);
            errors    = 0;
            for (int s = 0; s < NSLOT; s++) begin
                filed_wheel[s] = 1'b0;
                filed_wait[s]  = 1'b0;
                due_tick[s]    = '0;
                slot_state[s]  = twst_pkg::SM_RUNNING;
            end
        endfunction

        function void push_beat(logic [twst_pkg::SLOT_FW-1:0] slot,
                                logic [twst_pkg::STAT_W-1:0] status, logic last);
            t_result_beat b;
            b.slot   = slot;
            b.status = status;
            b.last   = last;
            due_beats.push_back(b);
        endfunction

        function void note_command(logic [twst_pkg::MODE_W-1:0] mode,
                                   logic [twst_pkg::SLOT_FW-1:0] slot,
                                   logic [twst_pkg::TICK_W-1:0] ticks);
            int unsigned cap;
            int          hits [$];
            case (mode)
                twst_pkg::MODE_SLEEP, twst_pkg::MODE_WAIT: begin
                    // a slot already waiting is pulled off first, then filed again
                    filed_wheel[slot] = 1'b0;
                    filed_wait[slot]  = 1'b0;
                    if (mode == twst_pkg::MODE_SLEEP && ticks != '0) begin
                        due_tick[slot]    = now_count + ticks;
                        filed_wheel[slot] = 1'b1;
                        slot_state[slot]  = twst_pkg::SM_INTR;
                    end else begin
                        filed_wait[slot] = 1'b1;
                        slot_state[slot] = (mode == twst_pkg::MODE_WAIT)
                                         ? twst_pkg::SM_UNINTR : twst_pkg::SM_INTR;
                    end
                    push_beat(slot, twst_pkg::ST_OK, 1'b1);
                end
                twst_pkg::MODE_WAKE: begin
                    if (slot_state[slot] == twst_pkg::SM_INTR ||
                        slot_state[slot] == twst_pkg::SM_UNINTR) begin
                        filed_wheel[slot] = 1'b0;
                        filed_wait[slot]  = 1'b0;
                        slot_state[slot]  = twst_pkg::SM_RUNNING;
                        push_beat(slot, twst_pkg::ST_OK, 1'b1);
                    end else begin
                        push_beat(slot, twst_pkg::ST_NOTWAIT, 1'b1);
                    end
                end
                twst_pkg::MODE_TICK: now_count = now_count + 1;
                twst_pkg::MODE_COLLECT: begin
                    cap = (ready_cap > NSLOT) ? NSLOT : ready_cap;
                    for (int s = 0; s < NSLOT && hits.size() < cap; s++) begin
                        // same bucket but a later wakeup stays on the wheel
                        if (filed_wheel[s] &&
                            due_tick[s][twst_pkg::WHEEL_BITS-1:0] ==
                                now_count[twst_pkg::WHEEL_BITS-1:0] &&
                            due_tick[s] <= now_count) begin
                            filed_wheel[s] = 1'b0;
                            filed_wait[s]  = 1'b0;
                            slot_state[s]  = twst_pkg::SM_RUNNING;
                            hits.push_back(s);
                        end
                    end
                    if (hits.size() == 0)
                        push_beat('0, twst_pkg::ST_NONE, 1'b1);
                    foreach (hits[i])
                        push_beat(twst_pkg::SLOT_FW'(hits[i]), twst_pkg::ST_TIMEOUT,
                                  i == hits.size() - 1);
                end
                default: ;  // unused modes are dropped
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            // keep the log short if the block is badly off
            if (errors <= 25)
                $display("mismatch: %s", msg);
        endtask

        task check_beat(logic [twst_pkg::SLOT_FW-1:0] slot,
                        logic [twst_pkg::STAT_W-1:0] status, logic last);
            t_result_beat want;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat slot=%0d status=%0d last=%0d",
                                          slot, status, last));
                return;
            end
            want = due_beats.pop_front();
            if (slot !== want.slot || status !== want.status || last !== want.last)
                report_mismatch($sformatf("got slot=%0d status=%0d last=%0d, want %0d/%0d/%0d",
                                          slot, status, last,
                                          want.slot, want.status, want.last));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [39:0]                   i_s_axis_tdata;   // [5:0] task_slot, [37:6] sleep_ticks, [39:38] zero
    logic [twst_pkg::MODE_W-1:0]   i_s_axis_tuser;   // [2:0] mode
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [7:0]                    o_m_axis_tdata;   // [5:0] out_slot, [7:6] zero
    logic [twst_pkg::STAT_W-1:0]   o_m_axis_tuser;   // [1:0] status
    logic                          o_m_axis_tlast;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [twst_pkg::CFG_W-1:0]    i_cfg_data;

    t_sleep_table_sb sb;
    int src_idle   = 0;
    int sink_stall = 0;
    int item_count = 0;
    int quiet_cycles = 0;

    timer_wheel_sleep_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_beat(o_m_axis_tdata[twst_pkg::SLOT_FW-1:0], o_m_axis_tuser,
                          o_m_axis_tlast);
    end

    // watchdog: too long without any beat on any channel
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("[timer_wheel_sleep_table_core] ERROR");
                $finish;
            end
        end
    end

    // valid is left high after a beat, so back-to-back commands keep it asserted
    task automatic send_cmd(logic [twst_pkg::MODE_W-1:0] mode,
                            logic [twst_pkg::SLOT_FW-1:0] slot,
                            logic [twst_pkg::TICK_W-1:0] ticks);
        if ($urandom_range(99) < src_idle) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, ticks, slot};
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_command(mode, slot, ticks);
        item_count++;
    endtask

    task automatic settle(int tail);
        i_s_axis_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_max_ready(logic [twst_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.ready_cap = value;
    endtask

    function automatic logic [twst_pkg::SLOT_FW-1:0] pick_slot(bit want_waiting);
        logic [twst_pkg::SLOT_FW-1:0] s;
        s = twst_pkg::SLOT_FW'($urandom_range(NSLOT - 1));
        if (want_waiting) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (sb.slot_state[s] != twst_pkg::SM_RUNNING)
                    break;
                s = s + 1'b1;
            end
        end
        return s;
    endfunction

    function automatic logic [twst_pkg::TICK_W-1:0] far_ticks();
        case ($urandom_range(4))
            0: return $urandom;
            1: return twst_pkg::TICK_W'(twst_pkg::WHEEL_BUCKETS * $urandom_range(1, 3));
            // wraps to an earlier wakeup in the current bucket
            2: return '0 - twst_pkg::TICK_W'(twst_pkg::WHEEL_BUCKETS * $urandom_range(1, 3));
            3: return '1;
            default: return twst_pkg::TICK_W'(twst_pkg::WHEEL_BUCKETS - $urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [twst_pkg::SLOT_FW-1:0] any_slot();
        return twst_pkg::SLOT_FW'($urandom);
    endfunction

    task automatic run_sequence();
        int sel;
        int k;
        int d;
        int maxd;
        sel = $urandom_range(99);
        if (sel < 50) begin
            k = $urandom_range(1, 6);
            maxd = 0;
            repeat (k) begin
                d = $urandom_range(1, 4);
                if (d > maxd)
                    maxd = d;
                send_cmd(twst_pkg::MODE_SLEEP, pick_slot(1'b0), twst_pkg::TICK_W'(d));
                if ($urandom_range(4) == 0)
                    send_cmd(twst_pkg::MODE_WAKE, pick_slot($urandom_range(1) != 0), $urandom);
            end
            repeat (maxd) begin
                send_cmd(twst_pkg::MODE_TICK, any_slot(), $urandom);
                if ($urandom_range(9) != 0)
                    send_cmd(twst_pkg::MODE_COLLECT, any_slot(), $urandom);
            end
        end else if (sel < 62) begin
            k = $urandom_range(1, 4);
            repeat (k) begin
                if ($urandom_range(1) != 0)
                    send_cmd(twst_pkg::MODE_SLEEP, pick_slot(1'b0), '0);
                else
                    send_cmd(twst_pkg::MODE_WAIT, pick_slot(1'b0), $urandom);
            end
            repeat ($urandom_range(1, 4))
                send_cmd(twst_pkg::MODE_WAKE, pick_slot($urandom_range(3) != 0), $urandom);
        end else if (sel < 72) begin
            send_cmd(twst_pkg::MODE_WAKE, pick_slot($urandom_range(1) != 0), $urandom);
        end else if (sel < 82) begin
            send_cmd(twst_pkg::MODE_SLEEP, pick_slot(1'b0), far_ticks());
        end else if (sel < 87) begin
            send_cmd(MODE_ERR_BASE + twst_pkg::MODE_W'($urandom_range(2)), any_slot(),
                     $urandom);
        end else begin
            send_cmd(twst_pkg::MODE_COLLECT, any_slot(), $urandom);
        end
    endtask

    initial begin
        logic [twst_pkg::CFG_W-1:0] cfg_plan [8];
        int                         seg_end;
        sb = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= twst_pkg::MODE_SLEEP;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        cfg_plan = '{7'd127, 7'd2, 7'd64, 7'd0, 7'd1, 7'd65, 7'd6, 7'd0};
        cfg_plan[7] = twst_pkg::CFG_W'($urandom_range(3, 63));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty collect, wake of a running slot, re-filing,
        // same-bucket later wakeup, release order and unused modes
        send_cmd(twst_pkg::MODE_COLLECT, 6'd33, '1);
        send_cmd(twst_pkg::MODE_WAKE, 6'd5, '0);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd0, 32'd1);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd63, 32'd1);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd10, '0);
        send_cmd(twst_pkg::MODE_WAIT, 6'd11, '1);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd20, twst_pkg::TICK_W'(twst_pkg::WHEEL_BUCKETS));
        send_cmd(twst_pkg::MODE_SLEEP, 6'd21, '1);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd10, 32'd1);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd63, 32'd2);
        send_cmd(twst_pkg::MODE_COLLECT, 6'd0, '0);
        send_cmd(twst_pkg::MODE_TICK, 6'd63, 32'h5555_5555);
        send_cmd(twst_pkg::MODE_COLLECT, 6'd42, 32'hAAAA_AAAA);
        send_cmd(twst_pkg::MODE_TICK, 6'd0, '0);
        send_cmd(twst_pkg::MODE_COLLECT, 6'd0, '0);
        send_cmd(twst_pkg::MODE_WAKE, 6'd11, '0);
        send_cmd(twst_pkg::MODE_WAKE, 6'd11, '0);
        send_cmd(twst_pkg::MODE_WAKE, 6'd21, '1);
        send_cmd(twst_pkg::MODE_WAIT, 6'd30, 32'd5);
        send_cmd(twst_pkg::MODE_SLEEP, 6'd30, 32'd3);
        send_cmd(MODE_ERR_BASE, 6'd63, '1);
        send_cmd(MODE_ERR_BASE + twst_pkg::MODE_W'(1), 6'd21, 32'h8000_0001);
        send_cmd(MODE_ERR_BASE + twst_pkg::MODE_W'(2), 6'd42, $urandom);
        send_cmd(twst_pkg::MODE_WAKE, 6'd0, 32'hFFFF_0000);

        for (int seg = 0; seg < 8; seg++) begin
            case (seg / 2)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 84; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 84; end
                default: begin src_idle = 13; sink_stall = 13; end
            endcase
            settle(10);
            write_max_ready(cfg_plan[seg]);
            seg_end = DIRECTED + (seg + 1) * SEG_ITEMS;
            while (item_count < seg_end)
                run_sequence();
        end

        settle(150);
        if (sb.errors == 0)
            $display("[timer_wheel_sleep_table_core] OK");
        else
            $display("[timer_wheel_sleep_table_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/twst_pkg.sv
rtl/timer_wheel_sleep_table_core.sv
sim/timer_wheel_sleep_table_core_tb.sv
